/* src/dur_pkg.sv */
// Shared types, constants and helper functions for the duration string parser.
// Used by every module of the block and by its port checker; depends on nothing.
`timescale 1ns / 1ps

package dur_pkg;

  // Datapath width (matches the result port) and the width the total wraps at
  localparam int DW          = 64;
  localparam int VALUE_WIDTH = 64;
  localparam int HW          = DW / 2;

  // Widest suffix multiplier (31536000) fits in 25 bits
  localparam int MW = 25;

  // Token queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Result buffer at the output
  localparam int RES_DEPTH = 2;
  localparam int RES_AW    = $clog2(RES_DEPTH);

  // Configuration port
  localparam int CFG_IW = 2;
  localparam logic [CFG_IW-1:0] REG_DEFAULT  = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] REG_ERROR    = CFG_IW'(1);
  localparam logic [CFG_IW-1:0] REG_INFINITY = CFG_IW'(2);

  // Magnitude limits of a number: VSIGN for negative, VSIGN - 1 for positive
  localparam logic [DW-1:0] VSIGN     = DW'(1) << (VALUE_WIDTH - 1);
  localparam logic [DW-1:0] INF_RESET = {1'b0, {(DW-1){1'b1}}};

  // Infinity word tracking: count of matched letters, or broken
  localparam logic [3:0] INF_SHORT  = 4'd3;
  localparam logic [3:0] INF_FULL   = 4'd8;
  localparam logic [3:0] INF_BROKEN = 4'd15;
  localparam logic [7:0] INF_WORD [8] = '{"i", "n", "f", "i", "n", "i", "t", "y"};

  typedef enum logic [1:0] {
    ST_PARSED  = 2'd0,
    ST_DEFAULT = 2'd1,
    ST_ERROR   = 2'd2,
    ST_INF     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    SFX_NONE,
    SFX_S,
    SFX_M,
    SFX_H,
    SFX_D,
    SFX_W,
    SFX_Y
  } sfx_t;

  // One classified character, front to back
  typedef struct packed {
    logic       absent;
    logic       lookup_failed;
    logic       is_nul;
    logic       space;
    logic       sign;
    logic       minus;
    logic       digit;
    logic       oct;
    logic       hex_ok;
    logic       is_x;
    logic [3:0] dval;
    sfx_t       sfx;
    logic [7:0] inf_hit;
  } token_t;

  // Work for the accumulator: add term * multiplier, and/or emit a result
  typedef struct packed {
    logic          add;
    logic [DW-1:0] term;
    sfx_t          sfx;
    logic          emit;
    status_t       status;
  } op_t;

  typedef struct packed {
    logic [DW-1:0] value;
    status_t       status;
  } res_t;

  function automatic logic [MW-1:0] sfx_mult(sfx_t s);
    logic [MW-1:0] m;
    unique case (s)
      SFX_S:   m = MW'(1);
      SFX_M:   m = MW'(60);
      SFX_H:   m = MW'(60 * 60);
      SFX_D:   m = MW'(60 * 60 * 24);
      SFX_W:   m = MW'(60 * 60 * 24 * 7);
      SFX_Y:   m = MW'(60 * 60 * 24 * 365);
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

/* src/dur_front.sv */
// Front end: takes characters from the input port and classifies them into tokens.
// Depends on dur_pkg; feeds dur_queue.
`timescale 1ns / 1ps

module dur_front import dur_pkg::*; (
  input  logic       push,
  output logic       full,
  input  logic [7:0] ch,
  input  logic       absent,
  input  logic       lookup_failed,
  input  logic       q_full,
  output logic       q_push,
  output token_t     q_token
);

  logic [7:0] lc;
  logic [7:0] hv;

  // Input transfer goes straight into the token queue
  assign q_push = push && !q_full;
  assign full   = q_full;

  // Lower-case fold for letters
  assign lc = (ch >= "A" && ch <= "Z") ? ch + 8'd32 : ch;

  // Hex digit value; only meaningful with hex_ok
  always_comb begin
    if (ch >= "0" && ch <= "9") begin
      hv = ch - "0";
    end else begin
      hv = lc - "a" + 8'd10;
    end
  end

  always_comb begin
    q_token               = '0;
    q_token.absent        = absent;
    q_token.lookup_failed = lookup_failed;
    q_token.is_nul        = (ch == 8'h00);
    q_token.space         = (ch == " ") || (ch >= 8'd9 && ch <= 8'd13);
    q_token.sign          = (ch == "+") || (ch == "-");
    q_token.minus         = (ch == "-");
    q_token.digit         = (ch >= "0" && ch <= "9");
    q_token.oct           = (ch >= "0" && ch <= "7");
    q_token.hex_ok        = (ch >= "0" && ch <= "9") || (lc >= "a" && lc <= "f");
    q_token.is_x          = (lc == "x");
    q_token.dval          = hv[3:0];
    unique case (lc)
      "s":     q_token.sfx = SFX_S;
      "m":     q_token.sfx = SFX_M;
      "h":     q_token.sfx = SFX_H;
      "d":     q_token.sfx = SFX_D;
      "w":     q_token.sfx = SFX_W;
      "y":     q_token.sfx = SFX_Y;
      default: q_token.sfx = SFX_NONE;
    endcase
    // Which letter positions of the infinity word this character matches
    for (int k = 0; k < 8; k++) begin
      q_token.inf_hit[k] = (lc == INF_WORD[k]);
    end
  end

endmodule

/* src/dur_queue.sv */
// Short token queue between the classifying front and the parsing back.
// Depends on dur_pkg.
`timescale 1ns / 1ps

module dur_queue import dur_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr,
  input  token_t wr_token,
  output logic   full,
  input  logic   rd,
  output logic   valid,
  output token_t rd_token
);

  token_t         slots [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign full     = (count == (QAW+1)'(QDEPTH));
  assign valid    = (count != '0);
  assign rd_token = slots[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == QAW'(QDEPTH - 1)) ? '0 : wr_ptr + QAW'(1);
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == QAW'(QDEPTH - 1)) ? '0 : rd_ptr + QAW'(1);
      end
      count <= count + (QAW+1)'(wr) - (QAW+1)'(rd);
    end
  end

  // Token storage
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_token;
    end
  end

endmodule

/* src/dur_parse.sv */
// Parser: walks the number/suffix grammar one token per cycle unless the op register is held, and issues
// add and result operations to the accumulator. Depends on dur_pkg.
`timescale 1ns / 1ps

module dur_parse import dur_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   tok_valid,
  input  token_t tok,
  output logic   tok_pop,
  input  logic   op_ready,
  output logic   op_valid,
  output op_t    op
);

  typedef enum logic [2:0] {
    PH_START,
    PH_SPACE,
    PH_SIGN,
    PH_NUMBER,
    PH_HEXPFX
  } ph_t;

  typedef enum logic [1:0] {
    RX_DEC,
    RX_OCT,
    RX_HEX,
    RX_LEAD0
  } rx_t;

  ph_t           phase, phase_next;
  rx_t           radix, radix_next;
  logic [DW-1:0] number, number_next;
  logic          neg, neg_next;
  logic          saw, saw_next;
  logic          oor, oor_next;
  logic          failed, failed_next;
  logic [3:0]    inf_match, inf_next;

  op_t           op_n;
  logic          load;
  logic          first_d;
  logic          dig;
  logic          endn;
  logic          clr;
  logic [DW+3:0] n_w;
  logic [DW+3:0] d_w;
  logic [DW+3:0] wide;
  logic [DW+3:0] limit_w;
  logic          ovf;
  logic [DW-1:0] term;

  // A token moves on when the op register is free or draining
  assign load    = tok_valid && (!op_valid || op_ready);
  assign tok_pop = load;

  // Next magnitude for one more digit, and its overflow check
  assign n_w     = (DW+4)'(number);
  assign d_w     = (DW+4)'(tok.dval);
  assign limit_w = (DW+4)'(neg ? VSIGN : VSIGN - DW'(1));
  always_comb begin
    if (phase == PH_HEXPFX || radix == RX_HEX) begin
      wide = (n_w << 4) + d_w;
    end else if (radix == RX_OCT || radix == RX_LEAD0) begin
      wide = (n_w << 3) + d_w;
    end else begin
      wide = (n_w << 3) + (n_w << 1) + d_w;
    end
  end
  assign ovf  = (wide > limit_w);
  assign term = neg ? (DW'(0) - number) : number;

  // Grammar step
  always_comb begin
    phase_next  = phase;
    radix_next  = radix;
    number_next = number;
    neg_next    = neg;
    saw_next    = saw;
    oor_next    = oor;
    failed_next = failed;
    inf_next    = inf_match;
    op_n        = '0;
    first_d     = 1'b0;
    dig         = 1'b0;
    endn        = 1'b0;
    clr         = 1'b0;

    priority if (tok.absent) begin
      op_n.emit   = 1'b1;
      op_n.status = ST_DEFAULT;
      clr         = 1'b1;
    end else if (tok.lookup_failed) begin
      op_n.emit   = 1'b1;
      op_n.status = ST_ERROR;
      clr         = 1'b1;
    end else if (!tok.is_nul) begin
      // Track the whole-string infinity match regardless of parse faults
      if (inf_match < INF_FULL && tok.inf_hit[inf_match[2:0]]) begin
        inf_next = inf_match + 4'd1;
      end else begin
        inf_next = INF_BROKEN;
      end
      if (!failed) begin
        unique case (phase)
          PH_START, PH_SPACE: begin
            priority if (tok.space) begin
              phase_next = PH_SPACE;
            end else if (tok.sign) begin
              neg_next   = tok.minus;
              phase_next = PH_SIGN;
            end else if (tok.digit) begin
              first_d = 1'b1;
            end else begin
              failed_next = 1'b1;
            end
          end
          PH_SIGN: begin
            if (tok.digit) begin
              first_d = 1'b1;
            end else begin
              failed_next = 1'b1;
            end
          end
          PH_HEXPFX: begin
            if (tok.hex_ok) begin
              radix_next = RX_HEX;
              dig        = 1'b1;
              phase_next = PH_NUMBER;
            end else begin
              failed_next = 1'b1;
            end
          end
          PH_NUMBER: begin
            priority if (radix == RX_HEX && tok.hex_ok) begin
              dig = 1'b1;
            end else if ((radix == RX_OCT || radix == RX_LEAD0) && tok.oct) begin
              radix_next = RX_OCT;
              dig        = 1'b1;
            end else if (radix == RX_DEC && tok.digit) begin
              dig = 1'b1;
            end else if (radix == RX_LEAD0 && tok.is_x) begin
              phase_next = PH_HEXPFX;
            end else if (tok.sfx != SFX_NONE) begin
              endn = 1'b1;
            end else begin
              failed_next = 1'b1;
            end
          end
          default: begin
            failed_next = 1'b1;
          end
        endcase
      end
    end else begin
      // End of string: decide the kind of result
      op_n.emit = 1'b1;
      clr       = 1'b1;
      priority if (inf_match == INF_SHORT || inf_match == INF_FULL) begin
        op_n.status = ST_INF;
      end else if (failed) begin
        op_n.status = ST_ERROR;
      end else if (phase == PH_NUMBER) begin
        if (oor || !saw) begin
          op_n.status = ST_ERROR;
        end else begin
          op_n.add    = 1'b1;
          op_n.term   = term;
          op_n.sfx    = SFX_S;
          op_n.status = ST_PARSED;
        end
      end else if (phase != PH_START) begin
        op_n.status = ST_ERROR;
      end else begin
        op_n.status = ST_PARSED;
      end
    end

    // First digit of a number: a leading zero selects octal or hex
    if (first_d) begin
      number_next = DW'(tok.dval);
      saw_next    = 1'b1;
      radix_next  = (tok.dval == 4'd0) ? RX_LEAD0 : RX_DEC;
      phase_next  = PH_NUMBER;
    end

    // Further digit with overflow latch
    if (dig) begin
      saw_next = 1'b1;
      if (!oor) begin
        if (ovf) begin
          oor_next = 1'b1;
        end else begin
          number_next = wide[DW-1:0];
        end
      end
    end

    // Suffix closes the number
    if (endn) begin
      if (oor || !saw) begin
        failed_next = 1'b1;
      end else begin
        op_n.add  = 1'b1;
        op_n.term = term;
        op_n.sfx  = tok.sfx;
      end
      number_next = '0;
      neg_next    = 1'b0;
      radix_next  = RX_DEC;
      saw_next    = 1'b0;
      oor_next    = 1'b0;
      phase_next  = PH_START;
    end

    // Any result starts a fresh query
    if (clr) begin
      phase_next  = PH_START;
      radix_next  = RX_DEC;
      number_next = '0;
      neg_next    = 1'b0;
      saw_next    = 1'b0;
      oor_next    = 1'b0;
      failed_next = 1'b0;
      inf_next    = '0;
    end
  end

  // Parser state and the op register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_START;
      radix     <= RX_DEC;
      number    <= '0;
      neg       <= 1'b0;
      saw       <= 1'b0;
      oor       <= 1'b0;
      failed    <= 1'b0;
      inf_match <= '0;
      op_valid  <= 1'b0;
      op        <= '0;
    end else begin
      if (load) begin
        phase     <= phase_next;
        radix     <= radix_next;
        number    <= number_next;
        neg       <= neg_next;
        saw       <= saw_next;
        oor       <= oor_next;
        failed    <= failed_next;
        inf_match <= inf_next;
        op_valid  <= op_n.add || op_n.emit;
        op        <= op_n;
      end else if (op_ready) begin
        op_valid <= 1'b0;
      end
    end
  end

endmodule

/* src/dur_accum.sv */
// Accumulator: split multiply by the suffix constant, running total, value
// registers and the result buffer. Depends on dur_pkg.
`timescale 1ns / 1ps

module dur_accum import dur_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              op_valid,
  input  op_t               op,
  output logic              op_ready,
  input  logic              wr_en,
  input  logic [CFG_IW-1:0] wr_index,
  input  logic [DW-1:0]     wr_data,
  output logic              empty,
  input  logic              pop,
  output logic [DW-1:0]     value,
  output logic [1:0]        status
);

  logic [DW-1:0]      default_q;
  logic [DW-1:0]      error_q;
  logic [DW-1:0]      infinity_q;

  logic [MW-1:0]      mult;
  logic [HW+MW-1:0]   lo_prod;
  logic [HW-1:0]      hi_prod;

  logic               m_valid;
  logic [HW+MW-1:0]   m_lo;
  logic [HW-1:0]      m_hi;
  logic               m_add;
  logic               m_emit;
  status_t            m_status;
  logic               take_m;

  logic [DW-1:0]      total;
  logic [DW-1:0]      product;
  logic [DW-1:0]      sum;
  res_t               res_new;

  res_t               res_slots [RES_DEPTH];
  logic [RES_AW-1:0]  res_wp;
  logic [RES_AW-1:0]  res_rp;
  logic [RES_AW:0]    res_cnt;
  logic               res_full;
  logic               res_wr;
  logic               res_rd;

  // Value registers
  always_ff @(posedge clk) begin
    if (rst) begin
      default_q  <= '0;
      error_q    <= '0;
      infinity_q <= INF_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_DEFAULT:  default_q  <= wr_data;
        REG_ERROR:    error_q    <= wr_data;
        REG_INFINITY: infinity_q <= wr_data;
        default:      ;
      endcase
    end
  end

  // Multiply stage: partial products of the low and high 32-bit halves, registered
  assign mult    = sfx_mult(op.sfx);
  assign lo_prod = (HW+MW)'(op.term[HW-1:0]) * (HW+MW)'(mult);
  assign hi_prod = HW'(op.term[DW-1:HW] * HW'(mult));

  assign take_m   = m_valid && (!m_emit || !res_full);
  assign op_ready = !m_valid || take_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (op_ready) begin
      m_valid <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (op_valid && op_ready) begin
      m_lo     <= lo_prod;
      m_hi     <= hi_prod;
      m_add    <= op.add;
      m_emit   <= op.emit;
      m_status <= op.status;
    end
  end

  // Accumulate stage: merge partials and add into the running total
  assign product = {m_hi, HW'(0)} + DW'(m_lo);
  assign sum     = total + (m_add ? product : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (take_m) begin
      if (m_emit) begin
        total <= '0;
      end else if (m_add) begin
        total <= sum;
      end
    end
  end

  // Result value by kind
  always_comb begin
    res_new.status = m_status;
    unique case (m_status)
      ST_PARSED:  res_new.value = DW'($signed(sum[VALUE_WIDTH-1:0]));
      ST_DEFAULT: res_new.value = default_q;
      ST_ERROR:   res_new.value = error_q;
      ST_INF:     res_new.value = infinity_q;
      default:    res_new.value = error_q;
    endcase
  end

  // Result buffer
  assign res_full = (res_cnt == (RES_AW+1)'(RES_DEPTH));
  assign empty    = (res_cnt == '0);
  assign res_wr   = take_m && m_emit;
  assign res_rd   = pop && !empty;
  assign value    = res_slots[res_rp].value;
  assign status   = res_slots[res_rp].status;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wp  <= '0;
      res_rp  <= '0;
      res_cnt <= '0;
    end else begin
      if (res_wr) begin
        res_wp <= (res_wp == RES_AW'(RES_DEPTH - 1)) ? '0 : res_wp + RES_AW'(1);
      end
      if (res_rd) begin
        res_rp <= (res_rp == RES_AW'(RES_DEPTH - 1)) ? '0 : res_rp + RES_AW'(1);
      end
      res_cnt <= res_cnt + (RES_AW+1)'(res_wr) - (RES_AW+1)'(res_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (res_wr) begin
      res_slots[res_wp] <= res_new;
    end
  end

endmodule

/* src/duration_string_parser.sv */
// Path: a string-ending item's result passes the token queue, parse register,
//   multiply register and result buffer; other items give none.
// Throughput: one character per cycle; stalls only when the four-entry token
//   queue or the two-entry result buffer fills. Results leave one per cycle.
// Reset (synchronous): empties both queues, restarts the parse, and sets the
//   default, error and infinity values to 0, 0 and the largest positive value.
`timescale 1ns / 1ps

module duration_string_parser import dur_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           ch,
  input  logic                 absent,
  input  logic                 lookup_failed,
  output logic                 empty,
  input  logic                 pop,
  output logic signed [DW-1:0] value,
  output logic [1:0]           status,
  input  logic                 wr_en,
  input  logic [CFG_IW-1:0]    wr_index,
  input  logic [DW-1:0]        wr_data
);

  logic          q_full;
  logic          q_push;
  token_t        q_wtok;
  logic          q_valid;
  token_t        q_rtok;
  logic          q_pop;
  logic          op_valid;
  logic          op_ready;
  op_t           op;
  logic [DW-1:0] value_u;

  // Front: classify characters
  dur_front u_front (
    .push          (push),
    .full          (full),
    .ch            (ch),
    .absent        (absent),
    .lookup_failed (lookup_failed),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_token       (q_wtok)
  );

  // Token queue
  dur_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_push),
    .wr_token (q_wtok),
    .full     (q_full),
    .rd       (q_pop),
    .valid    (q_valid),
    .rd_token (q_rtok)
  );

  // Back: grammar
  dur_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (q_valid),
    .tok       (q_rtok),
    .tok_pop   (q_pop),
    .op_ready  (op_ready),
    .op_valid  (op_valid),
    .op        (op)
  );

  // Back: arithmetic and results
  dur_accum u_accum (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op       (op),
    .op_ready (op_ready),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .empty    (empty),
    .pop      (pop),
    .value    (value_u),
    .status   (status)
  );

  assign value = $signed(value_u);

endmodule

/* src/dur_checker.sv */
// Port-level checker for duration_string_parser, attached by the bind below.
// Depends on dur_pkg.
`timescale 1ns / 1ps

module dur_checker import dur_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 push,
  input logic                 full,
  input logic [7:0]           ch,
  input logic                 absent,
  input logic                 lookup_failed,
  input logic                 empty,
  input logic                 pop,
  input logic signed [DW-1:0] value,
  input logic [1:0]           status,
  input logic                 wr_en,
  input logic [CFG_IW-1:0]    wr_index,
  input logic [DW-1:0]        wr_data
);

  logic [DW-1:0] def_sh;
  logic [DW-1:0] inf_sh;
  logic [3:0]    pending;
  logic          end_in;
  logic          out_take;

  // Queries ended at the input and not yet taken at the output
  assign end_in   = push && !full && (absent || lookup_failed || ch == 8'h00);
  assign out_take = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      def_sh  <= '0;
      inf_sh  <= INF_RESET;
      pending <= '0;
    end else begin
      if (wr_en && wr_index == REG_DEFAULT) begin
        def_sh <= wr_data;
      end
      if (wr_en && wr_index == REG_INFINITY) begin
        inf_sh <= wr_data;
      end
      pending <= pending + 4'(end_in) - 4'(out_take);
    end
  end

  // Reset leaves both sides open and nothing to deliver
  a_reset: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not cleared by reset");

  // No result without an ended query behind it
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (pending != 4'd0))
    else $error("result without an ended query");

  // A waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(value) && $stable(status)))
    else $error("waiting result changed");

  // Default and infinity results carry the written values
  a_default: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == ST_DEFAULT) |-> (value == def_sh))
    else $error("default result does not match register");

  a_infinity: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == ST_INF) |-> (value == inf_sh))
    else $error("infinity result does not match register");

endmodule

bind duration_string_parser dur_checker u_dur_checker (
  .clk           (clk),
  .rst           (rst),
  .push          (push),
  .full          (full),
  .ch            (ch),
  .absent        (absent),
  .lookup_failed (lookup_failed),
  .empty         (empty),
  .pop           (pop),
  .value         (value),
  .status        (status),
  .wr_en         (wr_en),
  .wr_index      (wr_index),
  .wr_data       (wr_data)
);

/* tb/duration_string_parser_checker.sv */
// Port checker for the duration string parser: predicts each string's result and
// compares it with what leaves the result side. Depends on dur_pkg only.
`timescale 1ns / 1ps

module duration_string_parser_checker import dur_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic                 full,
  input  logic [7:0]           ch,
  input  logic                 absent,
  input  logic                 lookup_failed,
  input  logic                 empty,
  input  logic                 pop,
  input  logic signed [DW-1:0] value,
  input  logic [1:0]           status,
  input  logic                 wr_en,
  input  logic [CFG_IW-1:0]    wr_index,
  input  logic [DW-1:0]        wr_data,
  output int                   mismatches,
  output int                   outstanding
);

  typedef enum logic [2:0] {AT_TERM, IN_SPACE, AFTER_SIGN, IN_DIGITS, AFTER_0X} stage_t;
  typedef enum logic [1:0] {BASE_DEC, BASE_OCT, BASE_HEX, BASE_ZERO} base_t;

  localparam logic [63:0] SPELLED_INF = "infinity";

  // Suffix multipliers in seconds
  localparam logic [DW-1:0] SECS_S = DW'(1);
  localparam logic [DW-1:0] SECS_M = DW'(60);
  localparam logic [DW-1:0] SECS_H = DW'(60 * 60);
  localparam logic [DW-1:0] SECS_D = DW'(60 * 60 * 24);
  localparam logic [DW-1:0] SECS_W = DW'(60 * 60 * 24 * 7);
  localparam logic [DW-1:0] SECS_Y = DW'(60 * 60 * 24 * 365);

  // Register copies
  logic [DW-1:0] dflt_val, err_val, inf_val;

  // Parse state of the string in flight
  stage_t        stage;
  base_t         radix_kind;
  logic [DW-1:0] mag;
  logic [DW-1:0] total;
  logic          neg, seen, too_big, bad;
  logic [3:0]    inf_cnt;

  res_t expected_durations[$];
  res_t want;
  res_t fresh;
  bit   got_one;

  function automatic void clear_number();
    mag        = '0;
    neg        = 1'b0;
    radix_kind = BASE_DEC;
    seen       = 1'b0;
    too_big    = 1'b0;
  endfunction

  // Accumulate one digit, flagging magnitude overflow against the signed limit
  task automatic add_digit(input logic [DW-1:0] d, input logic [DW-1:0] radix);
    logic [DW-1:0] lim;
    lim  = neg ? VSIGN : VSIGN - DW'(1);
    seen = 1'b1;
    if (!too_big) begin
      if (mag > (lim - d) / radix) too_big = 1'b1;
      else mag = mag * radix + d;
    end
  endtask

  task automatic start_number(input logic [7:0] c);
    mag = '0;
    add_digit(DW'(c - "0"), DW'(10));
    radix_kind = (c == "0") ? BASE_ZERO : BASE_DEC;
    stage      = IN_DIGITS;
  endtask

  // Fold the finished number, times its multiplier, into the total
  task automatic close_number(input logic [DW-1:0] mult);
    logic [DW-1:0] term;
    if (too_big || !seen) begin
      bad = 1'b1;
    end else begin
      term  = neg ? ('0 - mag) : mag;
      total = total + term * mult;
    end
    clear_number();
    stage = AT_TERM;
  endtask

  // One accepted item: advance the parse, return a result when the query ends
  task automatic fold_char(input logic [7:0] c, input logic no_cap, input logic lk_err,
                           output bit done, output res_t r);
    logic [7:0]    lc;
    logic [4:0]    hv;
    logic          is_ws, is_dig;
    logic [DW-1:0] mult;
    done   = 1'b0;
    r      = '0;
    lc     = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    is_ws  = (c == " ") || (c >= 8'd9 && c <= 8'd13);
    is_dig = (c >= "0" && c <= "9");
    if (is_dig) hv = 5'(c - "0");
    else if (c >= "a" && c <= "f") hv = 5'(c - "a" + 8'd10);
    else if (c >= "A" && c <= "F") hv = 5'(c - "A" + 8'd10);
    else hv = 5'd16;

    if (no_cap) begin
      done = 1'b1;
      r.value  = dflt_val;
      r.status = ST_DEFAULT;
    end else if (lk_err) begin
      done = 1'b1;
      r.value  = err_val;
      r.status = ST_ERROR;
    end else if (c != 8'h00) begin
      // whole-string infinity match runs beside the number parse
      if (inf_cnt < INF_FULL && lc == SPELLED_INF[63 - 8 * inf_cnt -: 8])
        inf_cnt = inf_cnt + 4'd1;
      else inf_cnt = INF_BROKEN;
      if (!bad) begin
        case (stage)
          AT_TERM, IN_SPACE: begin
            if (is_ws) stage = IN_SPACE;
            else if (c == "+" || c == "-") begin
              neg   = (c == "-");
              stage = AFTER_SIGN;
            end else if (is_dig) start_number(c);
            else bad = 1'b1;
          end
          AFTER_SIGN: begin
            if (is_dig) start_number(c);
            else bad = 1'b1;
          end
          AFTER_0X: begin
            if (hv < 16) begin
              radix_kind = BASE_HEX;
              add_digit(DW'(hv), DW'(16));
              stage = IN_DIGITS;
            end else bad = 1'b1;
          end
          default: begin
            if (radix_kind == BASE_HEX && hv < 16) begin
              add_digit(DW'(hv), DW'(16));
            end else if ((radix_kind == BASE_OCT || radix_kind == BASE_ZERO) &&
                         c >= "0" && c <= "7") begin
              radix_kind = BASE_OCT;
              add_digit(DW'(c - "0"), DW'(8));
            end else if (radix_kind == BASE_DEC && is_dig) begin
              add_digit(DW'(c - "0"), DW'(10));
            end else if (radix_kind == BASE_ZERO && (c == "x" || c == "X")) begin
              stage = AFTER_0X;
            end else begin
              // anything else must be a unit suffix
              case (lc)
                "s":     mult = SECS_S;
                "m":     mult = SECS_M;
                "h":     mult = SECS_H;
                "d":     mult = SECS_D;
                "w":     mult = SECS_W;
                "y":     mult = SECS_Y;
                default: mult = '0;
              endcase
              if (mult == '0) bad = 1'b1;
              else close_number(mult);
            end
          end
        endcase
      end
    end else begin
      // terminating NUL
      done = 1'b1;
      if (inf_cnt == INF_SHORT || inf_cnt == INF_FULL) begin
        r.value  = inf_val;
        r.status = ST_INF;
      end else begin
        if (!bad) begin
          if (stage == IN_DIGITS) close_number(SECS_S);
          else if (stage != AT_TERM) bad = 1'b1;
        end
        if (bad) begin
          r.value  = err_val;
          r.status = ST_ERROR;
        end else begin
          r.value  = total;
          r.status = ST_PARSED;
        end
      end
    end

    if (done) begin
      stage   = AT_TERM;
      total   = '0;
      bad     = 1'b0;
      inf_cnt = '0;
      clear_number();
    end
  endtask

  // Watch both channels and the register port
  always @(posedge clk) begin
    if (rst) begin
      dflt_val   = '0;
      err_val    = '0;
      inf_val    = INF_RESET;
      stage      = AT_TERM;
      total      = '0;
      bad        = 1'b0;
      inf_cnt    = '0;
      mismatches = 0;
      clear_number();
      expected_durations.delete();
    end else begin
      if (pop && !empty) begin
        if (expected_durations.size() == 0) begin
          mismatches++;
          $error("result transfer with nothing expected: value %0d status %0d", value, status);
        end else begin
          want = expected_durations.pop_front();
          if (value !== want.value) begin
            mismatches++;
            $error("value: expected %0d, got %0d", $signed(want.value), value);
          end
          if (status !== want.status) begin
            mismatches++;
            $error("status: expected %0d, got %0d", want.status, status);
          end
        end
      end
      if (push && !full) begin
        fold_char(ch, absent, lookup_failed, got_one, fresh);
        if (got_one) expected_durations.push_back(fresh);
      end
      if (wr_en) begin
        case (wr_index)
          REG_DEFAULT:  dflt_val = wr_data;
          REG_ERROR:    err_val  = wr_data;
          REG_INFINITY: inf_val  = wr_data;
          default:      ;
        endcase
      end
    end
    outstanding <= expected_durations.size();
  end

endmodule

/* tb/duration_string_parser_tb.sv */
// Top of the duration string parser bench: clock, reset, string stimulus, register
// settings and verdict. Depends on dur_pkg, the parser and its port checker.
`timescale 1ns / 1ps

module duration_string_parser_tb;
  import dur_pkg::*;

  localparam int ITEM_TARGET = 850;
  localparam int PHASE_ITEMS = 190;
  localparam int IDLE_PCT    = 18;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;

  logic                 clk;
  logic                 rst           = 1'b1;
  logic                 push          = 1'b0;
  logic [7:0]           ch            = 8'h00;
  logic                 absent        = 1'b0;
  logic                 lookup_failed = 1'b0;
  logic                 pop           = 1'b0;
  logic                 wr_en         = 1'b0;
  logic [CFG_IW-1:0]    wr_index      = REG_DEFAULT;
  logic [DW-1:0]        wr_data       = '0;
  logic                 full, empty;
  logic signed [DW-1:0] value;
  logic [1:0]           status;

  int    mismatches, outstanding;
  int    sent        = 0;
  int    quiet       = 0;
  bit    steady      = 1'b0;
  bit    garble      = 1'b0;
  string hex_digits  = "0123456789abcdefABCDEF";
  string suffixes    = "smhdwySMHDWY";
  string inf_letters = "infinity";

  duration_string_parser dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .ch(ch), .absent(absent),
    .lookup_failed(lookup_failed), .empty(empty), .pop(pop), .value(value),
    .status(status), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  duration_string_parser_checker chk (
    .clk(clk), .rst(rst), .push(push), .full(full), .ch(ch), .absent(absent),
    .lookup_failed(lookup_failed), .empty(empty), .pop(pop), .value(value),
    .status(status), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Give up when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || wr_en) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: random pop gaps, plus long hold-offs that back the block up
  initial begin : receiver
    int taken;
    int hold;
    taken = 0;
    hold  = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        taken++;
        if (taken % 100 == 40) hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else begin
        pop <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // One input transfer, with random idle cycles ahead of it
  task automatic send(input logic [7:0] c, input logic no_cap = 1'b0,
                      input logic lk_err = 1'b0);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push          <= 1'b1;
    ch            <= c;
    absent        <= no_cap;
    lookup_failed <= lk_err;
    @(posedge clk);
    while (full) @(posedge clk);
    sent++;
  endtask

  // Character of a well-formed string, sometimes preceded by a stray byte
  task automatic put(input logic [7:0] c);
    if (garble && $urandom_range(29) == 0) send(8'($urandom_range(1, 255)));
    send(c);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send(s[i]);
    send(8'h00);
  endtask

  // Stop sending and wait until every expected result has been taken
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic load_regs(input logic [DW-1:0] d, input logic [DW-1:0] e,
                           input logic [DW-1:0] i);
    wr_en    <= 1'b1;
    wr_index <= REG_DEFAULT;
    wr_data  <= d;
    @(posedge clk);
    wr_index <= REG_ERROR;
    wr_data  <= e;
    @(posedge clk);
    wr_index <= REG_INFINITY;
    wr_data  <= i;
    @(posedge clk);
    wr_en    <= 1'b0;
  endtask

  function automatic logic [7:0] pick_space();
    return ($urandom_range(5) == 0) ? " " : 8'($urandom_range(9, 13));
  endfunction

  // One number of a duration: optional spaces and sign, digits, optional suffix
  task automatic send_term(input bit last);
    int nd;
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) put(pick_space());
    case ($urandom_range(5))
      0:       put("+");
      1:       put("-");
      default: ;
    endcase
    nd = ($urandom_range(11) == 0) ? $urandom_range(14, 22) : $urandom_range(1, 4);
    case ($urandom_range(3))
      0: begin
        put("0");
        put($urandom_range(1) ? "x" : "X");
        if ($urandom_range(15) == 0) nd = 0;
        repeat (nd) put(hex_digits[$urandom_range(21)]);
      end
      1: begin
        put("0");
        repeat (nd - 1) put(8'("0" + $urandom_range(7)));
      end
      default: begin
        put(8'("1" + $urandom_range(8)));
        repeat (nd - 1) put(8'("0" + $urandom_range(9)));
      end
    endcase
    if (!last || $urandom_range(9) < 7) put(suffixes[$urandom_range(11)]);
  endtask

  // One random query: mostly durations, some infinity words, flags and noise
  task automatic send_random_duration();
    int         kind, n, len;
    logic [7:0] c;
    kind   = $urandom_range(99);
    garble = ($urandom_range(4) == 0);
    if (kind < 3) begin
      repeat ($urandom_range(3)) put(8'("0" + $urandom_range(9)));
      send(8'($urandom_range(255)), 1'b1, 1'($urandom_range(1)));
    end else if (kind < 6) begin
      repeat ($urandom_range(3)) put(8'("0" + $urandom_range(9)));
      send(8'($urandom_range(255)), 1'b0, 1'b1);
    end else if (kind < 11) begin
      case ($urandom_range(9))
        0, 1, 2, 3: len = 3;
        4, 5, 6, 7: len = 8;
        8:          len = $urandom_range(1, 7);
        default:    len = 9;
      endcase
      for (int k = 0; k < len; k++) begin
        c = (k < 8) ? inf_letters[k] : "x";
        if ($urandom_range(1)) c = c - 8'd32;
        send(c);
      end
      send(8'h00);
    end else if (kind < 18) begin
      repeat ($urandom_range(1, 6)) send(8'($urandom_range(1, 255)));
      send(8'h00);
    end else begin
      n = $urandom_range(1, 3);
      for (int t = 0; t < n; t++) send_term(t == n - 1);
      if ($urandom_range(19) == 0) put(pick_space());
      send(8'h00);
    end
  endtask

  initial begin : stimulus
    int goal;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed strings under reset register values
    send_text("");
    send_text("inf");
    send_text("InFiNiTy");
    send_text("infin");
    send_text("9223372036854775807");
    send_text("-9223372036854775808");
    send_text("9223372036854775808");
    send_text("0x7FFFFFFFFFFFFFFFs");
    send_text("-0X8000000000000000");
    send_text("  +017h\t-3M0x1fD");
    send_text("2w1Y5d");
    send_text("300000000000y");
    send_text("08");
    send_text("0x");
    send_text("5 ");
    send_text("+");
    send_text("7q");
    send(8'h80);
    send(8'hFF);
    send(8'h00);
    // both flags at once: absent wins
    send("1");
    send(8'hFF, 1'b1, 1'b1);
    // lookup failure and absence in the middle of a string
    send("4");
    send(8'h00, 1'b0, 1'b1);
    send("7");
    send(8'h55, 1'b1, 1'b0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       load_regs(VSIGN, INF_RESET, '0);
        1:       load_regs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
        2:       load_regs(INF_RESET, VSIGN, VSIGN);
        default: load_regs('1, DW'(1), {$urandom, $urandom});
      endcase
      steady = (ph == 1);
      goal   = (ph == 3) ? ITEM_TARGET : sent + PHASE_ITEMS;
      while (sent < goal) send_random_duration();
      drain();
    end

    if (mismatches == 0 && outstanding == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
